FILE: src/ibmw_pkg.sv
package ibmw_pkg;

   localparam int SLOT_COUNT          = 15;
   localparam int DIRECT_SLOTS        = 12;
   localparam int MAX_LOG_BLOCK       = 6;
   localparam int PTRS_LOG_BASE       = 8;
   localparam int BLOCK_LOG_BASE      = 10;
   localparam int WORD_SHIFT          = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int IDX_W               = 32;
   localparam int ADDR_W              = 48;
   localparam int SPAN_W              = 44;

   typedef enum logic [1:0] {
      MODE_LOAD_SLOT   = 2'd0,
      MODE_SET_LIMIT   = 2'd1,
      MODE_LOOKUP      = 2'd2,
      MODE_READ_RETURN = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_READ_REQ  = 2'd0,
      KIND_FOUND     = 2'd1,
      KIND_RANGE     = 2'd2,
      KIND_FAILED    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CLS_DIRECT = 3'd0,
      CLS_LEVEL1 = 3'd1,
      CLS_LEVEL2 = 3'd2,
      CLS_LEVEL3 = 3'd3,
      CLS_PAST   = 3'd4
   } class_type;

   typedef struct packed {
      mode_type           mode;
      logic [3:0]         slot_index;
      logic [31:0]        value_word;
      logic [IDX_W-1:0]   logical_index;
      logic               read_failed;
      class_type          cls;
      logic [IDX_W-1:0]   offset;
   } entry_type;

   // index bits resolved by one indirect block
   function automatic logic [3:0] digit_bits(input logic [2:0] eff_log);
      digit_bits = 4'(PTRS_LOG_BASE) + {1'b0, eff_log};
   endfunction

endpackage

FILE: src/indirect_block_map_walker.sv
// an accepted word is written into the queue, then the back end registers its result
// throughput: one word per cycle while busy is low; the back end drains the queue every cycle
// busy is high only while the queue between front and back end is full
// the receiver cannot stall; each result is shown for exactly one cycle
// synchronous reset clears pointer slots, block limit, walk state, queue and log_block_size
module indirect_block_map_walker
   import ibmw_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_slot_index,
   input  logic [31:0]        req_value_word,
   input  logic [IDX_W-1:0]   req_logical_index,
   input  logic               req_read_failed,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_kind,
   output logic [ADDR_W-1:0]  rsp_read_address,
   output logic [31:0]        rsp_block_number,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_write_data
);

   logic [2:0] log_block_ff;
   logic [2:0] log_block_in;
   logic [2:0] eff_log;
   logic       push;
   entry_type  push_entry;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;
   logic       full;

   assign log_block_in = csr_write_enable ? csr_write_data : log_block_ff;
   assign eff_log      = (log_block_ff > 3'(MAX_LOG_BLOCK)) ? 3'(MAX_LOG_BLOCK) : log_block_ff;
   assign busy         = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_block_ff <= '0;
      end else begin
         log_block_ff <= log_block_in;
      end
   end

   ibmw_front u_front (
      .start             (start),
      .busy              (full),
      .req_mode          (req_mode),
      .req_slot_index    (req_slot_index),
      .req_value_word    (req_value_word),
      .req_logical_index (req_logical_index),
      .req_read_failed   (req_read_failed),
      .eff_log           (eff_log),
      .push              (push),
      .push_entry        (push_entry)
   );

   ibmw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (full)
   );

   ibmw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (head_valid),
      .item             (head_entry),
      .eff_log          (eff_log),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_read_address (rsp_read_address),
      .rsp_block_number (rsp_block_number)
   );

endmodule

FILE: src/ibmw_front.sv
module ibmw_front
   import ibmw_pkg::*;
(
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_slot_index,
   input  logic [31:0]        req_value_word,
   input  logic [IDX_W-1:0]   req_logical_index,
   input  logic               req_read_failed,
   input  logic [2:0]         eff_log,
   output logic               push,
   output entry_type          push_entry
);

   logic [3:0]        k;
   logic [5:0]        k1;
   logic [5:0]        k2;
   logic [5:0]        k3;
   logic [SPAN_W-1:0] idx_w;
   logic [SPAN_W-1:0] span1;
   logic [SPAN_W-1:0] span2;
   logic [SPAN_W-1:0] span3;
   logic [SPAN_W-1:0] t1;
   logic [SPAN_W-1:0] t2;
   logic [SPAN_W-1:0] t3;
   logic [SPAN_W-1:0] base;
   logic [SPAN_W-1:0] diff;
   class_type         cls;

   assign push = start && !busy;

   always_comb begin
      k     = digit_bits(eff_log);
      k1    = {2'b00, k};
      k2    = k1 << 1;
      k3    = k1 + k2;
      span1 = SPAN_W'(1) << k1;
      span2 = SPAN_W'(1) << k2;
      span3 = SPAN_W'(1) << k3;
      t1    = SPAN_W'(DIRECT_SLOTS) + span1;
      t2    = t1 + span2;
      t3    = t2 + span3;
      idx_w = {{(SPAN_W-IDX_W){1'b0}}, req_logical_index};

      // first range that holds the index
      if (idx_w < SPAN_W'(DIRECT_SLOTS)) begin
         cls  = CLS_DIRECT;
         base = '0;
      end else if (idx_w < t1) begin
         cls  = CLS_LEVEL1;
         base = SPAN_W'(DIRECT_SLOTS);
      end else if (idx_w < t2) begin
         cls  = CLS_LEVEL2;
         base = t1;
      end else if (idx_w < t3) begin
         cls  = CLS_LEVEL3;
         base = t2;
      end else begin
         cls  = CLS_PAST;
         base = '0;
      end
      diff = idx_w - base;

      push_entry.mode          = mode_type'(req_mode);
      push_entry.slot_index    = req_slot_index;
      push_entry.value_word    = req_value_word;
      push_entry.logical_index = req_logical_index;
      push_entry.read_failed   = req_read_failed;
      push_entry.cls           = cls;
      push_entry.offset        = diff[IDX_W-1:0];
   end

endmodule

FILE: src/ibmw_queue.sv
module ibmw_queue
   import ibmw_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry,
   output logic      full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/ibmw_back.sv
module ibmw_back
   import ibmw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  entry_type          item,
   input  logic [2:0]         eff_log,
   output logic               pop,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_kind,
   output logic [ADDR_W-1:0]  rsp_read_address,
   output logic [31:0]        rsp_block_number
);

   logic [31:0]        slots_ff [SLOT_COUNT];
   logic [31:0]        slots_in [SLOT_COUNT];
   logic [31:0]        limit_ff;
   logic [31:0]        limit_in;
   logic [1:0]         levels_ff;
   logic [1:0]         levels_in;
   logic [IDX_W-1:0]   rem_ff;
   logic [IDX_W-1:0]   rem_in;
   logic               strobe_ff;
   logic               strobe_in;
   kind_type           kind_ff;
   kind_type           kind_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  addr_in;
   logic [31:0]        block_ff;
   logic [31:0]        block_in;

   logic [1:0]         cls_lv;
   logic [3:0]         rd_sel;
   logic [31:0]        slot_rd;
   logic               is_lookup;
   logic [31:0]        iss_ptr;
   logic [1:0]         iss_lv;
   logic [IDX_W-1:0]   iss_idx;
   logic [3:0]         k;
   logic [4:0]         sh;
   logic [IDX_W-1:0]   iss_slot;
   logic [IDX_W-1:0]   iss_rem;
   logic [4:0]         blk_shift;
   logic [ADDR_W-1:0]  iss_addr;

   assign pop              = item_valid;
   assign rsp_strobe       = strobe_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_read_address = addr_ff;
   assign rsp_block_number = block_ff;

   // shared read-request path for lookups and returned words
   always_comb begin
      case (item.cls)
         CLS_LEVEL1: cls_lv = 2'd1;
         CLS_LEVEL2: cls_lv = 2'd2;
         CLS_LEVEL3: cls_lv = 2'd3;
         default:    cls_lv = 2'd0;
      endcase
      if (item.cls == CLS_DIRECT) begin
         rd_sel = item.logical_index[3:0];
      end else begin
         rd_sel = 4'(DIRECT_SLOTS - 1) + {2'b00, cls_lv};
      end
      slot_rd = (rd_sel < 4'(SLOT_COUNT)) ? slots_ff[rd_sel] : '0;

      is_lookup = (item.mode == MODE_LOOKUP);
      if (is_lookup) begin
         iss_ptr = slot_rd;
         iss_lv  = cls_lv;
         iss_idx = item.offset;
      end else begin
         iss_ptr = item.value_word;
         iss_lv  = levels_ff - 2'd1;
         iss_idx = rem_ff;
      end

      k = digit_bits(eff_log);
      case (iss_lv)
         2'd2:    sh = {1'b0, k};
         2'd3:    sh = {k, 1'b0};
         default: sh = '0;
      endcase
      iss_slot  = iss_idx >> sh;
      iss_rem   = iss_idx & ((IDX_W'(1) << sh) - IDX_W'(1));
      blk_shift = 5'(BLOCK_LOG_BASE) + {2'b00, eff_log};
      iss_addr  = ({{(ADDR_W-32){1'b0}}, iss_ptr} << blk_shift)
                + ({{(ADDR_W-IDX_W){1'b0}}, iss_slot} << WORD_SHIFT);
   end

   always_comb begin
      slots_in  = slots_ff;
      limit_in  = limit_ff;
      levels_in = levels_ff;
      rem_in    = rem_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      addr_in   = '0;
      block_in  = '0;

      if (item_valid) begin
         case (item.mode)
            MODE_LOAD_SLOT: begin
               if (item.slot_index < 4'(SLOT_COUNT)) begin
                  slots_in[item.slot_index] = item.value_word;
               end
            end
            MODE_SET_LIMIT: begin
               limit_in = item.value_word;
            end
            MODE_LOOKUP: begin
               levels_in = '0;
               rem_in    = '0;
               strobe_in = 1'b1;
               if (item.logical_index >= limit_ff || item.cls == CLS_PAST) begin
                  kind_in = KIND_RANGE;
               end else if (item.cls == CLS_DIRECT) begin
                  kind_in  = KIND_FOUND;
                  block_in = slot_rd;
               end else if (iss_ptr == '0) begin
                  kind_in = KIND_FOUND;
               end else begin
                  kind_in   = KIND_READ_REQ;
                  addr_in   = iss_addr;
                  levels_in = iss_lv;
                  rem_in    = iss_rem;
               end
            end
            MODE_READ_RETURN: begin
               if (levels_ff != '0) begin
                  strobe_in = 1'b1;
                  levels_in = '0;
                  rem_in    = '0;
                  if (item.read_failed) begin
                     kind_in = KIND_FAILED;
                  end else if (levels_ff == 2'd1) begin
                     kind_in  = KIND_FOUND;
                     block_in = item.value_word;
                  end else if (iss_ptr == '0) begin
                     kind_in = KIND_FOUND;
                  end else begin
                     kind_in   = KIND_READ_REQ;
                     addr_in   = iss_addr;
                     levels_in = iss_lv;
                     rem_in    = iss_rem;
                  end
               end
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
         limit_ff  <= '0;
         levels_ff <= '0;
         rem_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         slots_ff  <= slots_in;
         limit_ff  <= limit_in;
         levels_ff <= levels_in;
         rem_ff    <= rem_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      block_ff <= block_in;
   end

endmodule
